@@ rtl/spmq_pkg.sv @@
// Package for the stable priority message queue.
// Holds the sizes, the command and status codes, the entry type and the cell operations.
// Used by spmq_cell and stable_priority_message_queue_unit.
package spmq_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_REQUEUE = 2'd1,
		CMD_POP     = 2'd2,
		CMD_PURGE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_PREV,
		CELL_FROM_NEXT
	} cell_op_t;

	typedef struct packed {
		logic [31:0]              handle;
		logic [31:0]              length;
		logic [PRIORITY_BITS-1:0] prio;
		logic [15:0]              user;
	} entry_t;

endpackage

@@ rtl/spmq_cell.sv @@
// One slot of the sorted queue chain.
// Holds one entry, compares it with the request priority and moves data to or from its neighbors.
// Depends on spmq_pkg.
module spmq_cell
	import spmq_pkg::*;
(
	input  logic                     clk,
	input  logic                     occupied,
	input  logic [PRIORITY_BITS-1:0] req_prio,
	input  logic                     ge_in,
	output logic                     ge_out,
	input  cell_op_t                 op,
	input  entry_t                   new_entry,
	input  entry_t                   prev_entry,
	input  entry_t                   next_entry,
	output entry_t                   entry
);

	entry_t entry_q;

	// The flag is true when this slot or any slot toward the tail holds an
	// entry of equal or higher priority than the request.
	assign ge_out = ge_in | (occupied & (entry_q.prio >= req_prio));
	assign entry  = entry_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_HOLD:      entry_q <= entry_q;
			CELL_LOAD:      entry_q <= new_entry;
			CELL_FROM_PREV: entry_q <= prev_entry;
			CELL_FROM_NEXT: entry_q <= next_entry;
			default:        entry_q <= entry_q;
		endcase
	end

endmodule

@@ rtl/stable_priority_message_queue_unit.sv @@
// Top level of the stable priority message queue: a chain of slot cells, the fill count,
// the queue number register and the result register. Depends on spmq_pkg and spmq_cell.
// A request may be accepted in every cycle while m_tready is high or no result is held;
// its result, set in the single result register, reaches the master side next cycle.
// Reset clears the fill count, the queue number and the result valid flag at once;
// the slot contents are not reset.
module stable_priority_message_queue_unit
	import spmq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [87:0]  s_tdata,   // data_handle, data_length, priority_req, user_id
	input  logic [1:0]   s_tuser,   // command
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // popped_handle, popped_length, popped_priority,
	                                // popped_user, popped_queue, entry_count, zero pad
	output logic [1:0]   m_tuser,   // status
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [9:0]   cfg_data   // queue_number
);

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_next;
	logic [9:0]               queue_number_q;
	logic                     m_tvalid_q;
	logic [103:0]             m_tdata_q;
	logic [1:0]               m_tuser_q;

	logic                     fire;
	cmd_t                     cmd;
	logic                     full;
	logic                     empty;
	logic [15:0]              prio_ext;
	logic [PRIORITY_BITS-1:0] req_prio;
	entry_t                   new_entry;
	entry_t                   head;
	logic [15:0]              head_prio_ext;

	logic [QUEUE_DEPTH-1:0]   occupied;
	logic [QUEUE_DEPTH-1:0]   ge_out;
	logic [QUEUE_DEPTH-1:0]   ge_in;
	logic [QUEUE_DEPTH-1:0]   at_after;
	cell_op_t                 cell_op [QUEUE_DEPTH];
	entry_t                   cell_entry [QUEUE_DEPTH];

	status_t                  status;
	logic [31:0]              res_handle;
	logic [31:0]              res_length;
	logic [7:0]               res_prio;
	logic [15:0]              res_user;
	logic [9:0]               res_queue;
	logic [15:0]              count_ext;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid_q || m_tready;
	assign fire      = s_tvalid && s_tready;
	assign cmd       = cmd_t'(s_tuser);
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);

	assign prio_ext           = 16'(s_tdata[71:64]);
	assign req_prio           = prio_ext[PRIORITY_BITS-1:0];
	assign new_entry.handle   = s_tdata[31:0];
	assign new_entry.length   = s_tdata[63:32];
	assign new_entry.prio     = req_prio;
	assign new_entry.user     = s_tdata[87:72];

	genvar g;
	generate
		for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
			assign occupied[g] = (CNT_W'(g) < count_q);
			assign at_after[g] = !ge_out[g];
			if (g == QUEUE_DEPTH - 1) begin : g_tail
				assign ge_in[g] = 1'b0;
			end else begin : g_mid
				assign ge_in[g] = ge_out[g+1];
			end
			spmq_cell u_cell (
				.clk        (clk),
				.occupied   (occupied[g]),
				.req_prio   (req_prio),
				.ge_in      (ge_in[g]),
				.ge_out     (ge_out[g]),
				.op         (cell_op[g]),
				.new_entry  (new_entry),
				.prev_entry (cell_entry[(g == 0) ? 0 : g - 1]),
				.next_entry (cell_entry[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
				.entry      (cell_entry[g])
			);
		end
	endgenerate

	// An insert goes directly behind the last slot whose priority is equal or
	// higher; every slot from there to the tail moves one place back.
	always_comb begin
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			cell_op[k] = CELL_HOLD;
			if (fire) begin
				case (cmd)
					CMD_INSERT: begin
						if (!full && at_after[k]) begin
							if (k == 0) begin
								cell_op[k] = CELL_LOAD;
							end else if (!at_after[k-1]) begin
								cell_op[k] = CELL_LOAD;
							end else begin
								cell_op[k] = CELL_FROM_PREV;
							end
						end
					end
					CMD_REQUEUE: begin
						if (!full && (CNT_W'(k) == count_q)) begin
							cell_op[k] = CELL_LOAD;
						end
					end
					CMD_POP: begin
						if (!empty && (k < QUEUE_DEPTH - 1)) begin
							cell_op[k] = CELL_FROM_NEXT;
						end
					end
					default: cell_op[k] = CELL_HOLD;
				endcase
			end
		end
	end

	assign head          = cell_entry[0];
	assign head_prio_ext = 16'(head.prio);

	always_comb begin
		status     = ST_OK;
		count_next = count_q;
		res_handle = '0;
		res_length = '0;
		res_prio   = '0;
		res_user   = '0;
		res_queue  = '0;
		case (cmd)
			CMD_INSERT, CMD_REQUEUE: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			CMD_POP: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					count_next = count_q - CNT_W'(1);
					res_handle = head.handle;
					res_length = head.length;
					res_prio   = head_prio_ext[7:0];
					res_user   = head.user;
					res_queue  = queue_number_q;
				end
			end
			default: count_next = '0;
		endcase
	end

	assign count_ext = 16'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			queue_number_q <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				queue_number_q <= cfg_data;
			end
			if (fire) begin
				count_q    <= count_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tuser_q <= status;
			m_tdata_q <= {1'b0, count_ext[4:0], res_queue, res_user, res_prio,
				res_length, res_handle};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("Fill count exceeds the queue depth.");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (cmd == CMD_INSERT || cmd == CMD_REQUEUE) && full)
		|=> (count_q == $past(count_q)))
		else $error("A request into a full queue changed the fill count.");

	a_result_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid)
		else $error("An accepted request produced no result.");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd == CMD_POP && empty) |=> (m_tuser == ST_EMPTY && m_tdata[87:0] == '0))
		else $error("A pop on an empty queue did not report empty.");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (cmd == CMD_INSERT || cmd == CMD_REQUEUE) && !full)
		|-> $onehot({(cell_op[0] == CELL_LOAD), at_after[QUEUE_DEPTH-1:1] == '0} )
			|| (cell_op[0] != CELL_LOAD))
		else $error("Insert position decode is inconsistent.");

endmodule
